@@ design/p2f_pkg.sv @@
// ---------------------------------------------------------------------------
// p2f_pkg: shared types and constants for the PCM to float32 converter
// Holds the sample-width codes and the word handed from assembler to
// the float stage.
// ---------------------------------------------------------------------------
`default_nettype none
package p2f_pkg;
  localparam logic [7:0] BPS_RESET = 8'd16;
  localparam logic [7:0] BPS_8  = 8'd8;
  localparam logic [7:0] BPS_16 = 8'd16;
  localparam logic [7:0] BPS_24 = 8'd24;
  localparam logic [7:0] BPS_32 = 8'd32;

  // assembled sample ready for conversion
  typedef struct packed {
    logic        err;
    logic        neg;
    logic [31:0] mag;    // 0 .. 2^31
    logic [4:0]  shift;  // divide by 2^shift
  } p2f_smp_t;
endpackage
`default_nettype wire

@@ design/pcm_to_float32_converter.sv @@
// ---------------------------------------------------------------------------
// pcm_to_float32_converter: PCM byte stream to normalized float32 samples
//
// Input channel in_valid/in_ready carries one PCM byte per word, least
// significant byte first. cfg_valid/cfg_ready writes bits_per_sample
// (8, 16, 24, 32; anything else flags every word as an error). A cfg write
// restarts byte gathering. Reset width is 16 bits.
// Result channel out_valid/out_ready carries sample_float_bits (sample /
// full scale as IEEE single, +0 for zero or error) and unsupported_width.
// Results are registered in the output slot, or in the skid slot if stalled.
// Throughput: one byte per cycle; the output register plus a skid stage
// let a new byte in while a result waits. When the receiver stalls with
// both slots full, in_ready drops. Reset clears the gathering state and
// both result slots; the float path is one priority encode, shift and round.
// ---------------------------------------------------------------------------
`default_nettype none
module pcm_to_float32_converter
  import p2f_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_bits_per_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_sample_float_bits,
  output logic             out_unsupported_width
);
  logic [7:0]  bps_r;
  logic        take, done, cfg_take;
  p2f_smp_t    smp;
  logic [31:0] fbits;

  // output slot and skid slot
  logic        ov_r, sv_r;
  logic [32:0] od_r, sd_r;

  assign in_ready  = ~sv_r;
  assign cfg_ready = 1'b1;
  assign take      = in_valid & in_ready;
  assign cfg_take  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) bps_r <= BPS_RESET;
    else if (cfg_take) bps_r <= cfg_bits_per_sample;
  end

  p2f_assemble u_asm (
    .clk, .rst_n, .bps(bps_r), .clr(cfg_take), .take,
    .data_byte(in_data_byte), .done, .smp
  );

  p2f_float u_flt (.smp, .fbits);

  logic push;
  assign push = take & done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      if (!ov_r || out_ready) begin
        // output slot drains; refill from skid first, then new result
        if (sv_r) begin
          ov_r <= 1'b1;
          od_r <= sd_r;
          sv_r <= push;
          if (push) sd_r <= {smp.err, fbits};
        end else begin
          ov_r <= push;
          if (push) od_r <= {smp.err, fbits};
        end
      end else if (push) begin
        sv_r <= 1'b1;
        sd_r <= {smp.err, fbits};
      end
    end
  end

  assign out_valid             = ov_r;
  assign out_unsupported_width = od_r[32];
  assign out_sample_float_bits = od_r[31:0];
endmodule
`default_nettype wire

@@ design/p2f_assemble.sv @@
// ---------------------------------------------------------------------------
// p2f_assemble: byte gathering and sign/magnitude split
// Collects little-endian bytes and emits one sample per completed word set.
// ---------------------------------------------------------------------------
`default_nettype none
module p2f_assemble
  import p2f_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] bps,
  input  wire logic       clr,
  input  wire logic       take,
  input  wire logic [7:0] data_byte,
  output logic            done,
  output p2f_smp_t        smp
);
  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] part_r, part_nxt;
  logic [2:0]  n;
  logic [31:0] raw;

  always_comb begin
    case (bps)
      BPS_8:   n = 3'd1;
      BPS_16:  n = 3'd2;
      BPS_24:  n = 3'd3;
      BPS_32:  n = 3'd4;
      default: n = 3'd0;
    endcase
  end

  always_comb begin
    raw = {8'd0, part_r};
    case (pos_r)
      2'd0:    raw = {24'd0, data_byte};
      2'd1:    raw = {16'd0, data_byte, part_r[7:0]};
      2'd2:    raw = {8'd0, data_byte, part_r[15:0]};
      default: raw = {data_byte, part_r};
    endcase
  end

  always_comb begin
    done     = 1'b1;
    pos_nxt  = 2'd0;
    part_nxt = 24'd0;
    smp      = '0;
    if (n == 3'd0) begin
      smp.err = 1'b1;
    end else if ({1'b0, pos_r} + 3'd1 < n) begin
      done     = 1'b0;
      pos_nxt  = pos_r + 2'd1;
      part_nxt = raw[23:0];
    end else begin
      case (n)
        3'd1: begin
          smp.neg   = ~raw[7];
          smp.mag   = raw[7] ? {24'd0, 1'b0, raw[6:0]} : 32'd128 - {24'd0, raw[7:0]};
          smp.shift = 5'd7;
        end
        3'd2: begin
          smp.neg   = raw[15];
          smp.mag   = raw[15] ? 32'd0 - {{16{1'b1}}, raw[15:0]} : {16'd0, raw[15:0]};
          smp.shift = 5'd15;
        end
        3'd3: begin
          smp.neg   = raw[23];
          smp.mag   = raw[23] ? 32'd0 - {{8{1'b1}}, raw[23:0]} : {8'd0, raw[23:0]};
          smp.shift = 5'd23;
        end
        default: begin
          smp.neg   = raw[31];
          smp.mag   = raw[31] ? 32'd0 - raw : raw;
          smp.shift = 5'd31;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      pos_r  <= 2'd0;
      part_r <= 24'd0;
    end else if (take) begin
      pos_r  <= pos_nxt;
      part_r <= part_nxt;
    end
  end
endmodule
`default_nettype wire

@@ design/p2f_float.sv @@
// ---------------------------------------------------------------------------
// p2f_float: magnitude to IEEE-754 single
// Priority encode, normalize shift and round to nearest even.
// ---------------------------------------------------------------------------
`default_nettype none
module p2f_float
  import p2f_pkg::*;
(
  input  p2f_smp_t    smp,
  output logic [31:0] fbits
);
  logic [4:0]  p;
  logic [31:0] norm;
  logic [24:0] q;
  logic        rnd;
  logic [7:0]  expo;

  always_comb begin
    p = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (smp.mag[i]) p = 5'(i);
    end
    norm = smp.mag << (5'd31 - p);          // leading one at bit 31
    // guard at bit 7, sticky below; only nonzero when p > 23
    rnd  = norm[7] && ((|norm[6:0]) || norm[8]);
    q    = {1'b0, norm[31:8]} + {24'd0, rnd};
    expo = 8'd127 + {3'd0, p} - {3'd0, smp.shift} + {7'd0, q[24]};
    if (smp.err || smp.mag == 32'd0) begin
      fbits = 32'd0;
    end else begin
      fbits = {smp.neg, expo, q[24] ? q[23:1] : q[22:0]};
    end
  end
endmodule
`default_nettype wire
